/* hw/rtl/ffba_pkg.sv */
// ffba_pkg: shared types, constants and the control program of the first-fit allocator.
// Used by ffba_seq, ffba_datapath, the top level and the checker. No dependencies.
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int HEADER_BYTES = 24;
    localparam int SIZE_W       = 24;
    localparam int ADDR_W       = 32;
    localparam int PADDR_W      = 3;
    localparam int STEP_W       = 4;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0640_0000;
    localparam logic [ADDR_W-1:0] HDR_OFFSET = ADDR_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(MAX_BLOCKS);

    // register index, taken from paddr[2]
    localparam logic REG_HEAP_BASE = 1'b0;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef struct packed {
        logic              command;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        status_t           status;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_IGNORE,
        C_FREE,
        C_END,
        C_AHIT,
        C_FHIT,
        C_FULL
    } cond_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_USE,
        WR_RELEASE,
        WR_NEW
    } wr_op_t;

    typedef enum logic [1:0] {
        PA_ZERO,
        PA_HIT,
        PA_NEW
    } pa_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC,
        IDX_CLR
    } idx_op_t;

    typedef struct packed {
        cond_sel_t cond_a;
        step_t     tgt_a;
        cond_sel_t cond_b;
        step_t     tgt_b;
        logic      loop;
        logic      idx_dec;
        wr_op_t    wr_op;
        logic      calc;
        logic      cnt_inc;
        pa_sel_t   pa_sel;
        status_t   status;
        logic      done;
    } ucode_t;

    typedef struct packed {
        idx_op_t idx_op;
        wr_op_t  wr_op;
        logic    calc;
        logic    cnt_inc;
        pa_sel_t pa_sel;
        status_t status;
        logic    done;
    } ctrl_t;

    typedef struct packed {
        logic ignore;
        logic is_free;
        logic scan_end;
        logic alloc_hit;
        logic free_hit;
        logic full;
    } flags_t;

    localparam step_t S_DISP0 = 4'd0;
    localparam step_t S_DISP1 = 4'd1;
    localparam step_t S_ASCAN = 4'd2;
    localparam step_t S_AHIT  = 4'd3;
    localparam step_t S_APP0  = 4'd4;
    localparam step_t S_APP1  = 4'd5;
    localparam step_t S_APP2  = 4'd6;
    localparam step_t S_FSCAN = 4'd7;
    localparam step_t S_FHIT  = 4'd8;
    localparam step_t S_IGN   = 4'd9;
    localparam step_t S_FULLW = 4'd10;
    localparam step_t S_UNKW  = 4'd11;

    function automatic ucode_t mk_word(cond_sel_t ca, step_t ta, cond_sel_t cb, step_t tb,
                                       logic lp, logic dec, wr_op_t wr, logic calc,
                                       logic cinc, pa_sel_t pa, status_t st, logic dn);
        ucode_t w;
        w.cond_a  = ca;
        w.tgt_a   = ta;
        w.cond_b  = cb;
        w.tgt_b   = tb;
        w.loop    = lp;
        w.idx_dec = dec;
        w.wr_op   = wr;
        w.calc    = calc;
        w.cnt_inc = cinc;
        w.pa_sel  = pa;
        w.status  = st;
        w.done    = dn;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        unique case (step)
            S_DISP0: w = mk_word(C_IGNORE, S_IGN, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_OK, 1'b0);
            S_DISP1: w = mk_word(C_FREE, S_FSCAN, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_OK, 1'b0);
            S_ASCAN: w = mk_word(C_END, S_APP0, C_AHIT, S_AHIT, 1'b1, 1'b0, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_OK, 1'b0);
            S_AHIT:  w = mk_word(C_NEVER, S_DISP0, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_USE,
                                 1'b0, 1'b0, PA_HIT, ST_OK, 1'b1);
            S_APP0:  w = mk_word(C_FULL, S_FULLW, C_NEVER, S_DISP0, 1'b0, 1'b1, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_OK, 1'b0);
            S_APP1:  w = mk_word(C_NEVER, S_DISP0, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_NONE,
                                 1'b1, 1'b0, PA_ZERO, ST_OK, 1'b0);
            S_APP2:  w = mk_word(C_NEVER, S_DISP0, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_NEW,
                                 1'b0, 1'b1, PA_NEW, ST_OK, 1'b1);
            S_FSCAN: w = mk_word(C_END, S_UNKW, C_FHIT, S_FHIT, 1'b1, 1'b0, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_OK, 1'b0);
            S_FHIT:  w = mk_word(C_NEVER, S_DISP0, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_RELEASE,
                                 1'b0, 1'b0, PA_ZERO, ST_OK, 1'b1);
            S_IGN:   w = mk_word(C_NEVER, S_DISP0, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_IGNORED, 1'b1);
            S_FULLW: w = mk_word(C_NEVER, S_DISP0, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_FULL, 1'b1);
            S_UNKW:  w = mk_word(C_NEVER, S_DISP0, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_UNKNOWN, 1'b1);
            default: w = mk_word(C_NEVER, S_DISP0, C_NEVER, S_DISP0, 1'b0, 1'b0, WR_NONE,
                                 1'b0, 1'b0, PA_ZERO, ST_OK, 1'b1);
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/ffba_seq.sv */
// ffba_seq: step counter, control ROM lookup and conditional jumps.
// Depends on ffba_pkg; drives the control word of ffba_datapath.
module ffba_seq
    import ffba_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  flags_t flags,
    output logic   busy,
    output logic   accept,
    output ctrl_t  ctrl
);

    step_t  step_reg;
    step_t  step_next;
    logic   busy_reg;
    logic   busy_next;
    ucode_t word;
    logic   jump_a;
    logic   jump_b;

    function automatic logic cond_true(cond_sel_t sel, flags_t f);
        logic r;
        unique case (sel)
            C_IGNORE: r = f.ignore;
            C_FREE:   r = f.is_free;
            C_END:    r = f.scan_end;
            C_AHIT:   r = f.alloc_hit;
            C_FHIT:   r = f.free_hit;
            C_FULL:   r = f.full;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;
    assign word   = ucode_rom(step_reg);
    assign jump_a = busy_reg && cond_true(word.cond_a, flags);
    assign jump_b = busy_reg && !jump_a && cond_true(word.cond_b, flags);

    always_comb
    begin
        ctrl.wr_op   = busy_reg ? word.wr_op : WR_NONE;
        ctrl.calc    = busy_reg && word.calc;
        ctrl.cnt_inc = busy_reg && word.cnt_inc;
        ctrl.pa_sel  = word.pa_sel;
        ctrl.status  = word.status;
        ctrl.done    = busy_reg && word.done;
        if (!busy_reg || word.done)
        begin
            ctrl.idx_op = IDX_CLR;
        end
        else if (word.idx_dec)
        begin
            ctrl.idx_op = IDX_DEC;
        end
        else if (word.loop && !jump_a && !jump_b)
        begin
            ctrl.idx_op = IDX_INC;
        end
        else
        begin
            ctrl.idx_op = IDX_HOLD;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            step_next = S_DISP0;
            if (start)
            begin
                busy_next = 1'b1;
            end
        end
        else if (word.done)
        begin
            busy_next = 1'b0;
            step_next = S_DISP0;
        end
        else if (jump_a)
        begin
            step_next = word.tgt_a;
        end
        else if (jump_b)
        begin
            step_next = word.tgt_b;
        end
        else if (!word.loop)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= S_DISP0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

/* hw/rtl/ffba_datapath.sv */
// ffba_datapath: block table memory, scan index, entry count, compares and result register.
// Depends on ffba_pkg; steered by the control word from ffba_seq.
module ffba_datapath
    import ffba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  req_t              request,
    input  logic [ADDR_W-1:0] heap_base,
    input  ctrl_t             ctrl,
    output flags_t            flags,
    output rsp_t              result,
    output logic              result_valid
);

    entry_t mem [MAX_BLOCKS];

    entry_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               cmd_reg;
    logic [SIZE_W:0]    aligned_reg;
    logic [ADDR_W-1:0]  rel_reg;
    logic [ADDR_W-1:0]  new_start_reg;
    rsp_t               result_reg;
    logic               valid_reg;

    logic [SIZE_W:0]    aligned_in;
    logic [SIZE_W:0]    size_dec;
    logic [ADDR_W-1:0]  hit_payload;
    rsp_t               result_next;

    assign aligned_in  = ({1'b0, request.request_size} + (SIZE_W+1)'(7))
                         & ~((SIZE_W+1)'(7));
    assign size_dec    = {(rd_data_reg.size == '0), rd_data_reg.size};
    assign hit_payload = rd_data_reg.start + HDR_OFFSET;

    always_comb
    begin
        flags.ignore    = (cmd_reg == CMD_FREE) ? (rel_reg == '0) : (aligned_reg == '0);
        flags.is_free   = (cmd_reg == CMD_FREE);
        flags.scan_end  = (idx_reg == count_reg);
        flags.alloc_hit = rd_data_reg.free && (size_dec >= aligned_reg);
        flags.free_hit  = (hit_payload == rel_reg);
        flags.full      = (count_reg == CNT_FULL);
    end

    always_comb
    begin
        case (ctrl.idx_op)
            IDX_INC: idx_next = idx_reg + 1'b1;
            IDX_DEC: idx_next = idx_reg - 1'b1;
            IDX_CLR: idx_next = '0;
            default: idx_next = idx_reg;
        endcase
    end

    assign count_next = ctrl.cnt_inc ? count_reg + 1'b1 : count_reg;
    assign rd_addr    = idx_next[IDX_W-1:0];

    always_comb
    begin
        wr_en   = (ctrl.wr_op != WR_NONE);
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_data_reg;
        case (ctrl.wr_op)
            WR_USE:
            begin
                wr_data.free = 1'b0;
            end
            WR_RELEASE:
            begin
                wr_data.free = 1'b1;
            end
            WR_NEW:
            begin
                wr_addr       = count_reg[IDX_W-1:0];
                wr_data.start = new_start_reg;
                wr_data.size  = aligned_reg[SIZE_W-1:0];
                wr_data.free  = 1'b0;
            end
            default:
            begin
                wr_data = rd_data_reg;
            end
        endcase
    end

    always_comb
    begin
        result_next.status = ctrl.status;
        case (ctrl.pa_sel)
            PA_HIT:  result_next.payload_address = hit_payload;
            PA_NEW:  result_next.payload_address = new_start_reg + HDR_OFFSET;
            default: result_next.payload_address = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= request.command;
            aligned_reg <= aligned_in;
            rel_reg     <= request.release_address;
        end
        if (ctrl.calc)
        begin
            new_start_reg <= (count_reg == '0) ? heap_base
                           : rd_data_reg.start + HDR_OFFSET + ADDR_W'(size_dec);
        end
        if (ctrl.done)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            valid_reg <= ctrl.done;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

/* hw/rtl/first_fit_block_allocator_unit.sv */
// First-fit block allocator: one request at a time, started by start while busy is low.
// Ignored requests skip the table scan; an alloc stops at the first free entry that fits
// or else tries to append a new entry; a free stops at the matching entry or the table end.
// Each request gives one result beat; the request rate is set by the one-entry-a-cycle
// table scan through the single read port. Reset clears the entry count and the sequencer;
// the table contents stay undefined until written, with no clearing pass.
module first_fit_block_allocator_unit
    import ffba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  req_t               request,
    output rsp_t               result,
    output logic               result_valid
);

    logic [ADDR_W-1:0] heap_base_reg;
    logic              accept;
    ctrl_t             ctrl;
    flags_t            flags;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign prdata  = (reg_sel == REG_HEAP_BASE) ? heap_base_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= BASE_RESET;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_HEAP_BASE))
        begin
            heap_base_reg <= pwdata;
        end
    end

    ffba_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .flags  (flags),
        .busy   (busy),
        .accept (accept),
        .ctrl   (ctrl)
    );

    ffba_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .request      (request),
        .heap_base    (heap_base_reg),
        .ctrl         (ctrl),
        .flags        (flags),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

/* hw/rtl/ffba_checker.sv */
// ffba_checker: port-level checks of the allocator's start/busy and result behavior.
// Depends on ffba_pkg; bound to first_fit_block_allocator_unit below.
module ffba_checker
    import ffba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input rsp_t result,
    input logic result_valid
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result beat while busy");

    a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result beat");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two result beats in a row");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != ST_OK) |-> (result.payload_address == '0))
        else $error("error result carries an address");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);
